@@ hw/rtl/tmfo_pkg.sv @@
// Package for the trading-minutes-from-open block: field widths, register
// indexes, session reset values and the control struct.
// No dependencies; compile first.
package tmfo_pkg;

  localparam int MIN_W   = 11;   // minute of day and result fields
  localparam int POS_W   = 12;   // linearised minute, session start or end
  localparam int SESS_W  = 24;   // packed start and end
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;    // six registers at 4-byte stride
  localparam int CNT_REG_W = 3;

  localparam logic [POS_W-1:0] DAY_MINUTES = POS_W'(24 * 60);
  localparam logic [POS_W:0]   PRE_OPEN    = (POS_W + 1)'(5);
  localparam logic [MIN_W-1:0] RESULT_CAP  = MIN_W'(24 * 60);

  // Default A-share sessions
  localparam logic [POS_W-1:0] AM_OPEN  = POS_W'(9 * 60 + 30);
  localparam logic [POS_W-1:0] AM_CLOSE = POS_W'(11 * 60 + 30);
  localparam logic [POS_W-1:0] PM_OPEN  = POS_W'(13 * 60);
  localparam logic [POS_W-1:0] PM_CLOSE = POS_W'(15 * 60);

  localparam logic [SESS_W-1:0] SESSION_0_RESET = {AM_OPEN, AM_CLOSE};
  localparam logic [SESS_W-1:0] SESSION_1_RESET = {PM_OPEN, PM_CLOSE};

  localparam logic              ENABLE_RESET        = 1'b1;
  localparam logic [CNT_REG_W-1:0] SESSION_COUNT_RESET = CNT_REG_W'(2);

  typedef enum logic [2:0] {
    REG_ENABLE        = 3'd0,
    REG_SESSION_COUNT = 3'd1,
    REG_SESSION_0     = 3'd2,
    REG_SESSION_1     = 3'd3,
    REG_SESSION_2     = 3'd4,
    REG_SESSION_3     = 3'd5
  } tmfo_reg_t;

  typedef struct packed {
    logic                 enable;
    logic [CNT_REG_W-1:0] session_count;
  } tmfo_ctrl_t;

  function automatic logic [SESS_W-1:0] session_reset(input int slot);
    logic [SESS_W-1:0] v;
    v = '0;
    if (slot == 0) v = SESSION_0_RESET;
    if (slot == 1) v = SESSION_1_RESET;
    return v;
  endfunction

endpackage

@@ hw/rtl/tmfo_if.sv @@
// Stream interfaces for bar minutes in and results out.
// Depends on tmfo_pkg.
interface tmfo_in_if;
  import tmfo_pkg::*;
  logic             valid;
  logic             ready;
  logic [MIN_W-1:0] clock_minute;
  modport source (output valid, output clock_minute, input ready);
  modport sink   (input valid, input clock_minute, output ready);
endinterface

interface tmfo_out_if;
  import tmfo_pkg::*;
  logic             valid;
  logic             ready;
  logic [MIN_W-1:0] elapsed_minutes;
  logic [MIN_W-1:0] total_minutes;
  logic             result_valid;
  modport source (output valid, output elapsed_minutes, output total_minutes,
                  output result_valid, input ready);
  modport sink   (input valid, input elapsed_minutes, input total_minutes,
                  input result_valid, output ready);
endinterface

@@ hw/rtl/tmfo_regs.sv @@
// APB-style register file: enable, session count and packed sessions.
// Depends on tmfo_pkg.
module tmfo_regs #(
  parameter int MAX_SESSIONS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tmfo_pkg::ADDR_W-1:0]   paddr,
  input  logic [tmfo_pkg::DATA_W-1:0]   pwdata,
  output logic [tmfo_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output tmfo_pkg::tmfo_ctrl_t          ctrl,
  output logic [MAX_SESSIONS-1:0][tmfo_pkg::POS_W-1:0] sess_start,
  output logic [MAX_SESSIONS-1:0][tmfo_pkg::POS_W-1:0] sess_end
);
  import tmfo_pkg::*;

  logic                              enable;
  logic [CNT_REG_W-1:0]              session_count;
  logic [MAX_SESSIONS-1:0][SESS_W-1:0] session;

  tmfo_reg_t reg_idx;
  logic      wr;
  logic [2:0] slot;

  assign reg_idx = tmfo_reg_t'(paddr[ADDR_W-1:2]);
  assign wr      = psel && penable && pwrite && pready;
  assign slot    = 3'(paddr[ADDR_W-1:2] - REG_SESSION_0);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= ENABLE_RESET;
      session_count <= SESSION_COUNT_RESET;
      for (int k = 0; k < MAX_SESSIONS; k++) session[k] <= session_reset(k);
    end else if (wr) begin
      unique case (reg_idx)
        REG_ENABLE:        enable        <= pwdata[0];
        REG_SESSION_COUNT: session_count <= pwdata[CNT_REG_W-1:0];
        REG_SESSION_0, REG_SESSION_1, REG_SESSION_2, REG_SESSION_3: begin
          for (int k = 0; k < MAX_SESSIONS; k++) begin
            if (int'(slot) == k) session[k] <= pwdata[SESS_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_ENABLE:        prdata = DATA_W'(enable);
      REG_SESSION_COUNT: prdata = DATA_W'(session_count);
      REG_SESSION_0, REG_SESSION_1, REG_SESSION_2, REG_SESSION_3: begin
        for (int k = 0; k < MAX_SESSIONS; k++) begin
          if (int'(slot) == k) prdata = DATA_W'(session[k]);
        end
      end
      default: prdata = '0;
    endcase
  end

  assign ctrl.enable        = enable;
  assign ctrl.session_count = session_count;

  always_comb begin
    for (int k = 0; k < MAX_SESSIONS; k++) begin
      sess_start[k] = session[k][SESS_W-1:POS_W];
      sess_end[k]   = session[k][POS_W-1:0];
    end
  end

endmodule

@@ hw/rtl/tmfo_calc.sv @@
// Combinational mapping of one minute of day to elapsed and total
// trading minutes. Depends on tmfo_pkg.
module tmfo_calc #(
  parameter int MAX_SESSIONS = 4
) (
  input  tmfo_pkg::tmfo_ctrl_t                         ctrl,
  input  logic [MAX_SESSIONS-1:0][tmfo_pkg::POS_W-1:0] sess_start,
  input  logic [MAX_SESSIONS-1:0][tmfo_pkg::POS_W-1:0] sess_end,
  input  logic [tmfo_pkg::MIN_W-1:0]                   clock_minute,
  output logic [tmfo_pkg::MIN_W-1:0]                   elapsed_minutes,
  output logic [tmfo_pkg::MIN_W-1:0]                   total_minutes,
  output logic                                         result_valid
);
  import tmfo_pkg::*;

  localparam int CNT_W = $clog2(MAX_SESSIONS + 1);
  localparam int IDX_W = (MAX_SESSIONS > 1) ? $clog2(MAX_SESSIONS) : 1;
  localparam int ACC_W = POS_W + CNT_W + 1;

  logic [CNT_W-1:0] n_use;
  logic [IDX_W-1:0] last_idx;
  logic [POS_W-1:0] last_end;
  logic             wrap;
  logic [POS_W-1:0] lin;
  logic [MAX_SESSIONS-1:0][POS_W-1:0] span;
  logic [MAX_SESSIONS:0][ACC_W-1:0]   prefix;
  logic [ACC_W-1:0] result;
  logic [ACC_W-1:0] total;

  // Clamp the session count into 1..MAX_SESSIONS
  always_comb begin
    if (ctrl.session_count == '0) begin
      n_use = CNT_W'(1);
    end else if (int'(ctrl.session_count) > MAX_SESSIONS) begin
      n_use = CNT_W'(MAX_SESSIONS);
    end else begin
      n_use = CNT_W'(ctrl.session_count);
    end
  end

  assign last_idx = IDX_W'(n_use - CNT_W'(1));
  assign last_end = sess_end[last_idx];

  // Move the after-midnight tail of the last session up by a day
  assign wrap = (last_end > DAY_MINUTES) &&
                ({1'b0, clock_minute} <= (last_end - DAY_MINUTES));
  assign lin  = {1'b0, clock_minute} + (wrap ? DAY_MINUTES : '0);

  always_comb begin
    prefix[0] = '0;
    for (int k = 0; k < MAX_SESSIONS; k++) begin
      span[k] = (sess_end[k] > sess_start[k]) ? sess_end[k] - sess_start[k] : '0;
      prefix[k+1] = prefix[k] +
                    ((k < int'(n_use)) ? ACC_W'(span[k]) : '0);
    end
  end

  assign total = prefix[MAX_SESSIONS];

  // First active session that the minute has not passed sets the count;
  // walk downward so the lowest index wins
  always_comb begin
    result = total;
    for (int k = MAX_SESSIONS - 1; k >= 0; k--) begin
      if ((k < int'(n_use)) && !((lin >= sess_start[k]) && (lin >= sess_end[k]))) begin
        if (lin >= sess_start[k]) begin
          result = prefix[k] + ACC_W'(lin - sess_start[k]) + ACC_W'(1);
        end else begin
          result = prefix[k];
        end
      end
    end
    if (({1'b0, lin} + PRE_OPEN) < {1'b0, sess_start[0]}) begin
      result = '0;
    end else if (lin <= sess_start[0]) begin
      result = ACC_W'(1);
    end
  end

  always_comb begin
    if (ctrl.enable) begin
      elapsed_minutes = (result > ACC_W'(RESULT_CAP)) ? RESULT_CAP : result[MIN_W-1:0];
      total_minutes   = (total > ACC_W'(RESULT_CAP)) ? RESULT_CAP : total[MIN_W-1:0];
      result_valid    = 1'b1;
    end else begin
      elapsed_minutes = '0;
      total_minutes   = '0;
      result_valid    = 1'b0;
    end
  end

endmodule

@@ hw/rtl/trading_minutes_from_open_unit.sv @@
// Top level of the trading-minutes-from-open block: input register,
// session mapping and result register. Depends on tmfo_pkg, tmfo_if,
// tmfo_regs and tmfo_calc.
//
// Each bar transaction carries a minute of the day; the matching result
// transaction gives the one-based count of trading minutes since the first
// session opened, the total session length and a flag that is low when the
// block is disabled. The block takes one transaction per clock while the
// downstream side is not stalling: the input register captures the minute
// on acceptance, and the session compares and prefix sums on that minute
// feed the result register. Both registers hold while the
// downstream side stalls, so the input keeps accepting until both stages
// are full. Sessions are written through the APB-style port as
// start*4096+end in linearised minutes and may run past midnight; checking
// that the list is well ordered is left to software. Write the registers
// only while no transaction is in flight.
module trading_minutes_from_open_unit #(
  parameter int MAX_SESSIONS = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tmfo_pkg::ADDR_W-1:0] paddr,
  input  logic [tmfo_pkg::DATA_W-1:0] pwdata,
  output logic [tmfo_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  tmfo_in_if.sink                     bar,
  tmfo_out_if.source                  result
);
  import tmfo_pkg::*;

  tmfo_ctrl_t ctrl;
  logic [MAX_SESSIONS-1:0][POS_W-1:0] sess_start;
  logic [MAX_SESSIONS-1:0][POS_W-1:0] sess_end;

  // Input stage
  logic             s1_valid;
  logic [MIN_W-1:0] s1_minute;

  // Result stage
  logic             out_valid;
  logic [MIN_W-1:0] out_elapsed;
  logic [MIN_W-1:0] out_total;
  logic             out_flag;

  logic [MIN_W-1:0] calc_elapsed;
  logic [MIN_W-1:0] calc_total;
  logic             calc_flag;

  logic s2_free;

  tmfo_regs #(.MAX_SESSIONS(MAX_SESSIONS)) u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .ctrl       (ctrl),
    .sess_start (sess_start),
    .sess_end   (sess_end)
  );

  tmfo_calc #(.MAX_SESSIONS(MAX_SESSIONS)) u_calc (
    .ctrl            (ctrl),
    .sess_start      (sess_start),
    .sess_end        (sess_end),
    .clock_minute    (s1_minute),
    .elapsed_minutes (calc_elapsed),
    .total_minutes   (calc_total),
    .result_valid    (calc_flag)
  );

  // The result register frees when empty or when its transaction is taken;
  // the input register frees when empty or when it can advance.
  assign s2_free   = !out_valid || result.ready;
  assign bar.ready = !s1_valid || s2_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (bar.ready) s1_valid <= bar.valid;
      if (s2_free)   out_valid <= s1_valid;
    end
  end

  // Payload registers: capture on acceptance, hold otherwise
  always_ff @(posedge clk) begin
    if (bar.valid && bar.ready) s1_minute <= bar.clock_minute;
    if (s1_valid && s2_free) begin
      out_elapsed <= calc_elapsed;
      out_total   <= calc_total;
      out_flag    <= calc_flag;
    end
  end

  assign result.valid           = out_valid;
  assign result.elapsed_minutes = out_elapsed;
  assign result.total_minutes   = out_total;
  assign result.result_valid    = out_flag;

endmodule

@@ test/tmfo_result_checker.sv @@
// Result checker for the trading-minutes-from-open block: tracks register
// writes on the APB-style port, predicts each result and compares it.
// Depends on tmfo_pkg and tmfo_if.
module tmfo_result_checker #(
  parameter int MAX_SESSIONS = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tmfo_pkg::ADDR_W-1:0] paddr,
  input  logic [tmfo_pkg::DATA_W-1:0] pwdata,
  input  logic                        pready,
  tmfo_in_if                          bar,
  tmfo_out_if                         result,
  output int                          failures,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tmfo_pkg::*;

  typedef struct packed {
    logic [MIN_W-1:0] elapsed;
    logic [MIN_W-1:0] total;
    logic             live;
  } minutes_result_t;

  logic                 en_q;
  logic [CNT_REG_W-1:0] cnt_q;
  logic [POS_W-1:0]     start_q [MAX_SESSIONS];
  logic [POS_W-1:0]     end_q   [MAX_SESSIONS];
  minutes_result_t      due_results [$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    failures++;
  endtask

  function automatic int unsigned session_span(input int k);
    return (end_q[k] > start_q[k]) ? int'(end_q[k]) - int'(start_q[k]) : 0;
  endfunction

  function automatic int unsigned cap_result(input int unsigned v);
    return (v > int'(RESULT_CAP)) ? int'(RESULT_CAP) : v;
  endfunction

  function automatic minutes_result_t minutes_since_open(input logic [MIN_W-1:0] mod);
    minutes_result_t r;
    int unsigned     n, minute, total, run, res, day, last_end;
    bit              done;
    r = '0;
    if (!en_q) return r;
    n = int'(cnt_q);
    if (n < 1) n = 1;
    if (n > MAX_SESSIONS) n = MAX_SESSIONS;
    total = 0;
    for (int k = 0; k < n; k++) total += session_span(k);
    day      = int'(DAY_MINUTES);
    last_end = int'(end_q[n-1]);
    minute   = int'(mod);
    // fold the early hours onto the tail of a session that ran past midnight
    if (last_end > day && minute <= last_end - day) minute += day;
    if (minute + int'(PRE_OPEN) < start_q[0]) begin
      res = 0;
    end else if (minute <= start_q[0]) begin
      res = 1;
    end else begin
      run  = 0;
      res  = 0;
      done = 1'b0;
      for (int k = 0; k < n && !done; k++) begin
        if (minute < start_q[k]) begin
          res  = run;
          done = 1'b1;
        end else if (minute < end_q[k]) begin
          res  = run + (minute - start_q[k]) + 1;
          done = 1'b1;
        end else begin
          run += session_span(k);
        end
      end
      if (!done) res = run;
    end
    r.elapsed = MIN_W'(cap_result(res));
    r.total   = MIN_W'(cap_result(total));
    r.live    = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    minutes_result_t got, want;
    int              k;
    if (rst) begin
      en_q  = ENABLE_RESET;
      cnt_q = SESSION_COUNT_RESET;
      for (int i = 0; i < MAX_SESSIONS; i++) begin
        start_q[i] = '0;
        end_q[i]   = '0;
      end
      start_q[0] = SESSION_0_RESET[SESS_W-1:POS_W];
      end_q[0]   = SESSION_0_RESET[POS_W-1:0];
      if (MAX_SESSIONS > 1) begin
        start_q[1] = SESSION_1_RESET[SESS_W-1:POS_W];
        end_q[1]   = SESSION_1_RESET[POS_W-1:0];
      end
      due_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_ENABLE:        en_q  = pwdata[0];
          REG_SESSION_COUNT: cnt_q = pwdata[CNT_REG_W-1:0];
          REG_SESSION_0, REG_SESSION_1, REG_SESSION_2, REG_SESSION_3: begin
            k = int'(paddr[ADDR_W-1:2]) - int'(REG_SESSION_0);
            if (k < MAX_SESSIONS) begin
              start_q[k] = pwdata[SESS_W-1:POS_W];
              end_q[k]   = pwdata[POS_W-1:0];
            end
          end
          default: ;
        endcase
      end
      // check the result first so that a stray one cannot claim a fresh prediction
      if (result.valid && result.ready) begin
        got = '{result.elapsed_minutes, result.total_minutes, result.result_valid};
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing due: elapsed %0d total %0d",
                                    got.elapsed, got.total));
        end else begin
          want = due_results.pop_front();
          if (got.elapsed !== want.elapsed)
            report_mismatch($sformatf("elapsed_minutes: got %0d, expected %0d",
                                      got.elapsed, want.elapsed));
          if (got.total !== want.total)
            report_mismatch($sformatf("total_minutes: got %0d, expected %0d",
                                      got.total, want.total));
          if (got.live !== want.live)
            report_mismatch($sformatf("result_valid: got %0b, expected %0b",
                                      got.live, want.live));
        end
      end
      if (bar.valid && bar.ready)
        due_results = {due_results, minutes_since_open(bar.clock_minute)};
    end
    pending = due_results.size();
  end

endmodule

@@ test/tb_trading_minutes_from_open_unit.sv @@
// Testbench top for trading_minutes_from_open_unit: drives bar transactions
// and APB-style register writes, gives the verdict.
// Depends on tmfo_pkg, tmfo_if, tmfo_result_checker and the block itself.
module tb_trading_minutes_from_open_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import tmfo_pkg::*;

  localparam int SEGMENT_ITEMS = 19;
  localparam int DRAIN_LIMIT   = 20000;

  // Register settings visited in the random part
  typedef enum int {
    SET_A_SHARE,
    SET_OVERNIGHT,
    SET_RANDOM_ORDERED,
    SET_RANDOM_RAW,
    SET_WIDE_OPEN,
    SET_DISABLED
  } setting_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                failures;
  int                pending;
  int                src_idle;
  int                snk_idle;

  // Copy of the sessions, used only to aim minutes at the boundaries
  logic [POS_W-1:0]     sh_start [4];
  logic [POS_W-1:0]     sh_end   [4];
  logic [CNT_REG_W-1:0] sh_cnt;

  setting_t schedule [8] = '{SET_RANDOM_ORDERED, SET_RANDOM_RAW, SET_OVERNIGHT,
                             SET_RANDOM_ORDERED, SET_WIDE_OPEN, SET_DISABLED,
                             SET_A_SHARE, SET_RANDOM_ORDERED};
  // Opens, closes and the pre-open window of the default sessions, plus the
  // ends of the minute range
  int a_share_probes [12] = '{0, 564, 565, 570, 571, 689, 700, 780, 899, 900, 1439, 2047};

  tmfo_in_if  bars ();
  tmfo_out_if results ();

  trading_minutes_from_open_unit #(
    .MAX_SESSIONS(4)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .bar     (bars),
    .result  (results)
  );

  tmfo_result_checker #(
    .MAX_SESSIONS(4)
  ) minutes_check (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .pready   (pready),
    .bar      (bars),
    .result   (results),
    .failures (failures),
    .pending  (pending)
  );

  always #5 clk = ~clk;

  // Receiver: hold ready low in reset, then drop it at random in the share
  // of cycles that snk_idle gives
  always @(posedge clk) begin
    results.ready <= rst ? 1'b0 : ($urandom_range(0, 99) >= snk_idle);
  end

  // Setup cycle, access cycle, then an idle cycle so that back-to-back writes
  // never lower and raise psel in the same step
  task automatic write_reg(input int idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_count(input logic [DATA_W-1:0] value);
    sh_cnt = value[CNT_REG_W-1:0];
    write_reg(REG_SESSION_COUNT, value);
  endtask

  task automatic write_session(input int k, input int st, input int fin,
                               input logic [7:0] junk);
    logic [POS_W-1:0] s, e;
    s = st[POS_W-1:0];
    e = fin[POS_W-1:0];
    sh_start[k] = s;
    sh_end[k]   = e;
    write_reg(int'(REG_SESSION_0) + k, {junk, s, e});
  endtask

  // Offer one bar transaction, idling first at random, and hold it until taken
  task automatic send_bar(input int minute);
    while ($urandom_range(0, 99) < src_idle) begin
      bars.valid <= 1'b0;
      @(posedge clk);
    end
    bars.valid        <= 1'b1;
    bars.clock_minute <= MIN_W'(minute);
    do @(posedge clk); while (!bars.ready);
  endtask

  // Drop valid and wait for every result in flight, then the pipeline depth
  task automatic settle();
    bars.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly minutes close to an open, a close, a folded tail or the pre-open
  // edge of a session in use; the rest spread over the day and past it
  function automatic int pick_minute();
    int used, k, base, off, m, sel;
    used = (sh_cnt < 1) ? 1 : (sh_cnt > 4) ? 4 : int'(sh_cnt);
    sel  = $urandom_range(0, 99);
    if (sel < 55) begin
      k = $urandom_range(0, used - 1);
      case ($urandom_range(0, 3))
        0:       base = int'(sh_start[k]);
        1:       base = int'(sh_end[k]);
        2:       base = int'(sh_end[used-1]) - int'(DAY_MINUTES);
        default: base = int'(sh_start[0]) - int'(PRE_OPEN);
      endcase
      off = $urandom_range(0, 12);
      m   = base + off - 6;
    end else if (sel < 92) begin
      m = $urandom_range(0, int'(DAY_MINUTES) - 1);
    end else begin
      m = $urandom_range(int'(DAY_MINUTES), (1 << MIN_W) - 1);
    end
    if (m < 0) m = 0;
    if (m > (1 << MIN_W) - 1) m = (1 << MIN_W) - 1;
    return m;
  endfunction

  task automatic apply_setting(input setting_t which);
    int n, t, st, fin;
    case (which)
      SET_A_SHARE: begin
        write_reg(REG_ENABLE, 1);
        write_count(2);
        write_session(0, 570, 690, 8'h00);
        write_session(1, 780, 900, 8'h00);
        write_session(2, 0, 0, 8'h00);
        write_session(3, 0, 0, 8'h00);
      end
      SET_OVERNIGHT: begin
        // night session over midnight, then the next day's sessions
        write_reg(REG_ENABLE, 1);
        write_count(4);
        write_session(0, 1260, 1590, 8'h00);
        write_session(1, 1980, 2055, 8'h00);
        write_session(2, 2070, 2130, 8'h00);
        write_session(3, 2250, 2340, 8'h00);
      end
      SET_RANDOM_ORDERED: begin
        write_reg(REG_ENABLE, 1);
        n = $urandom_range(1, 4);
        t = $urandom_range(0, 1400);
        for (int k = 0; k < 4; k++) begin
          st  = (t > 2879) ? 2879 : t;
          fin = st + $urandom_range(1, 300);
          if (fin > 2879) fin = 2879;
          write_session(k, st, fin, 8'h00);
          t = fin + $urandom_range(0, 200);
        end
        write_count(n);
      end
      SET_RANDOM_RAW: begin
        // any packing at all, with junk in the unused upper bits
        write_reg(REG_ENABLE, $urandom | 32'd1);
        for (int k = 0; k < 4; k++)
          write_session(k, $urandom_range(0, 4095), $urandom_range(0, 4095),
                        8'($urandom));
        write_count($urandom);
      end
      SET_WIDE_OPEN: begin
        // one session from near midnight to the last linear minute: every minute of
        // the day folds onto its tail and the count saturates
        write_reg(REG_ENABLE, 1);
        write_count(1);
        write_session(0, $urandom_range(0, 4), 2879, 8'h00);
        write_session(1, 0, 0, 8'h00);
        write_session(3, 2879, 2879, 8'h00);
      end
      default: begin
        write_reg(REG_ENABLE, 0);
      end
    endcase
  endtask

  initial begin
    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    bars.valid        <= 1'b0;
    bars.clock_minute <= '0;
    src_idle = 0;
    snk_idle = 0;
    sh_cnt   = SESSION_COUNT_RESET;
    sh_start = '{AM_OPEN, PM_OPEN, '0, '0};
    sh_end   = '{AM_CLOSE, PM_CLOSE, '0, '0};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: default sessions straight out of reset
    foreach (a_share_probes[i]) send_bar(a_share_probes[i]);

    // Writes past the register list must leave the results untouched
    settle();
    write_reg(int'(REG_SESSION_3) + 1, $urandom);
    write_reg(int'(REG_SESSION_3) + 2, $urandom);
    send_bar(700);

    // Disabled: results are reported missing
    settle();
    write_reg(REG_ENABLE, 0);
    send_bar(1439);
    send_bar(0);

    // Count of zero is taken as one; first open below the pre-open window
    settle();
    write_reg(REG_ENABLE, 1);
    write_count(0);
    write_session(0, 3, 10, 8'h00);
    send_bar(0);
    send_bar(3);
    send_bar(9);

    // Count above the slot count; empty and reversed sessions; a last end far
    // past midnight, so the total and some counts saturate
    settle();
    write_count(5);
    write_session(0, 570, 690, 8'h00);
    write_session(1, 800, 800, 8'h00);
    write_session(2, 700, 650, 8'h00);
    write_session(3, 1500, 4095, 8'h00);
    send_bar(0);
    send_bar(100);
    send_bar(2047);

    // Random part: three idling phases, each through every setting
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin src_idle = 23; snk_idle = 59; end
        1:       begin src_idle = 59; snk_idle = 23; end
        default: begin src_idle = 0;  snk_idle = 0;  end
      endcase
      foreach (schedule[s]) begin
        settle();
        apply_setting(schedule[s]);
        repeat (SEGMENT_ITEMS) send_bar(pick_minute());
      end
    end

    // Drain, bounded, then wait out the pipeline depth
    bars.valid <= 1'b0;
    @(posedge clk);
    for (int c = 0; c < DRAIN_LIMIT && pending != 0; c++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (failures == 0 && pending == 0) begin
      $display("tb_trading_minutes_from_open_unit: PASS");
    end else begin
      $display("tb_trading_minutes_from_open_unit: FAIL");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("tb_trading_minutes_from_open_unit: FAIL");
    $finish;
  end

endmodule
